@@ hw/rtl/bmlg_pkg.sv @@
// ----------------------------------------------------------------------------
// bmlg_pkg
// Shared types, constants and the luma function for the box-masked luma
// gradient block.
// ----------------------------------------------------------------------------
package bmlg_pkg;

  localparam int unsigned DIM_W   = 11;  // column, row, frame size, box side
  localparam int unsigned POS_W   = 12;  // signed box corner
  localparam int unsigned BOUND_W = 13;  // signed box bound, never wraps
  localparam int unsigned IDX_W   = 4;   // box index field
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned LUMA_W  = 8;

  // BT.709 weights, Q0.16
  localparam logic [15:0] LUMA_WR = 16'd13933;
  localparam logic [15:0] LUMA_WG = 16'd46871;
  localparam logic [15:0] LUMA_WB = 16'd4732;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  // register indexes on the configuration port
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // item codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_BOX   = 1'b1;

  typedef struct packed {
    logic                    en;
    logic [IDX_W-1:0]        index;
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] top;
    logic [DIM_W-1:0]        side;
  } box_wr_t;

  // truncated luma of a packed RGB word
  function automatic logic [LUMA_W-1:0] luma_of(input logic [PIX_W-1:0] pix);
    logic [24:0] acc;
    acc = 25'(LUMA_WR * pix[7:0]) + 25'(LUMA_WG * pix[15:8])
        + 25'(LUMA_WB * pix[23:16]);
    return acc[23:16];
  endfunction

endpackage

@@ hw/rtl/bmlg_box_store.sv @@
// ----------------------------------------------------------------------------
// bmlg_box_store
// Box register file and the parallel strictly-inside test for one position.
// ----------------------------------------------------------------------------
module bmlg_box_store import bmlg_pkg::*; #(
  parameter int NUM_BOXES = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  box_wr_t          wr,
  input  logic [DIM_W-1:0] column,
  input  logic [DIM_W-1:0] row,
  output logic             in_box
);

  logic signed [POS_W-1:0] box_left [NUM_BOXES];
  logic signed [POS_W-1:0] box_top  [NUM_BOXES];
  logic [DIM_W-1:0]        box_side [NUM_BOXES];
  logic [NUM_BOXES-1:0]    hit;

  logic signed [BOUND_W-1:0] col_s;
  logic signed [BOUND_W-1:0] row_s;

  assign col_s = {2'b00, column};
  assign row_s = {2'b00, row};

  for (genvar k = 0; k < NUM_BOXES; k++) begin : g_box
    logic signed [BOUND_W-1:0] left_e, top_e, right_e, bottom_e;

    always_ff @(posedge clk) begin
      if (rst) begin
        box_left[k] <= '0;
        box_top[k]  <= '0;
        box_side[k] <= '0;
      end else if (wr.en && ({1'b0, wr.index} == 5'(k))) begin
        box_left[k] <= wr.left;
        box_top[k]  <= wr.top;
        box_side[k] <= wr.side;
      end
    end

    assign left_e   = BOUND_W'(box_left[k]);
    assign top_e    = BOUND_W'(box_top[k]);
    assign right_e  = left_e + $signed({2'b00, box_side[k]});
    assign bottom_e = top_e + $signed({2'b00, box_side[k]});

    assign hit[k] = (col_s > left_e) && (col_s < right_e) &&
                    (row_s > top_e) && (row_s < bottom_e);
  end

  assign in_box = |hit;

endmodule

@@ hw/rtl/box_masked_luma_gradient_core.sv @@
// ----------------------------------------------------------------------------
// box_masked_luma_gradient_core
// Replaces pixels strictly inside any stored box by the absolute BT.709 luma
// difference to the previous in-box pixel of the row; others pass through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: cmd = 0 is
//   a raster-order pixel, cmd = 1 loads box entry box_index (out-of-range
//   indexes are dropped) and gives no output word.
//   Output channel (out_valid / out_stall) returns one word per pixel.
//   Configuration: cfg_write with cfg_index 0 sets frame_width, 1 sets
//   frame_height; only while the block is idle. Counters are not reset.
// Timing:
//   One word accepted per cycle while in_stall is low. A pixel's result is
//   registered on acceptance, in the output register or, if held, the skid.
//   The luma multiply-add, box compare and counter update are combinational,
//   since the next pixel needs the updated previous luma and position.
// Stall:
//   A second output register (skid) catches the word accepted while the
//   receiver stalls; in_stall rises only once the skid is full, so the
//   input never waits on the output register alone.
// Reset:
//   Synchronous, active high. Frame size returns to 640 x 480, counters and
//   previous luma to zero, all boxes to size zero (none active), both
//   output registers empty.
// ----------------------------------------------------------------------------
module box_masked_luma_gradient_core import bmlg_pkg::*; #(
  parameter int NUM_BOXES = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [PIX_W-1:0]        pixel_word,
  input  logic [IDX_W-1:0]        box_index,
  input  logic signed [POS_W-1:0] box_x,
  input  logic signed [POS_W-1:0] box_y,
  input  logic [DIM_W-1:0]        box_size,
  // output channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [PIX_W-1:0]        out_pixel_word
);

  // configuration registers
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  // stream state
  logic [DIM_W-1:0]  column_count, column_count_next;
  logic [DIM_W-1:0]  row_count, row_count_next;
  logic [LUMA_W-1:0] previous_luma, previous_luma_next;

  // skid register
  logic             skid_valid;
  logic [PIX_W-1:0] skid_word;

  logic             accept, pixel_in, pop, in_box;
  logic             col_wrap, row_wrap;
  logic [LUMA_W-1:0] luma, diff;
  logic [PIX_W-1:0] result;
  box_wr_t          box_wr;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign pixel_in = accept && (cmd == CMD_PIXEL);
  assign pop      = out_valid && !out_stall;

  // --- configuration ---
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // --- box store ---
  assign box_wr.en    = accept && (cmd == CMD_BOX);
  assign box_wr.index = box_index;
  assign box_wr.left  = box_x;
  assign box_wr.top   = box_y;
  assign box_wr.side  = box_size;

  bmlg_box_store #(
    .NUM_BOXES (NUM_BOXES)
  ) u_boxes (
    .clk    (clk),
    .rst    (rst),
    .wr     (box_wr),
    .column (column_count),
    .row    (row_count),
    .in_box (in_box)
  );

  // --- pixel path ---
  assign luma   = luma_of(pixel_word);
  assign diff   = (luma >= previous_luma) ? luma - previous_luma
                                          : previous_luma - luma;
  assign result = in_box ? {diff, diff, diff} : pixel_word;

  // wrap when count + 1 reaches the size, so a size of zero acts as one
  assign col_wrap = ({1'b0, column_count} + 12'd1) >= {1'b0, frame_width};
  assign row_wrap = ({1'b0, row_count} + 12'd1) >= {1'b0, frame_height};

  always_comb begin
    column_count_next  = column_count;
    row_count_next     = row_count;
    previous_luma_next = previous_luma;
    if (pixel_in) begin
      if (in_box) begin
        previous_luma_next = luma;
      end
      if (col_wrap) begin
        column_count_next  = '0;
        previous_luma_next = '0;    // row start
        row_count_next     = row_wrap ? '0 : row_count + 1'b1;
      end else begin
        column_count_next = column_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      previous_luma <= '0;
    end else begin
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      previous_luma <= previous_luma_next;
    end
  end

  // --- output register and skid ---
  // Accepts only happen with the skid empty, so a held main register
  // always has room in the skid for the new word.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || pixel_in;
      skid_valid <= 1'b0;
    end else if (pixel_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_pixel_word <= skid_valid ? skid_word : result;
    end
    if (out_valid && !pop && pixel_in) begin
      skid_word <= result;
    end
  end

endmodule

@@ dv/box_masked_luma_gradient_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_masked_luma_gradient_checker
// Watches the word channels and the configuration port of the core, predicts
// every output word and compares it with the word the core returns.
// ----------------------------------------------------------------------------
module box_masked_luma_gradient_checker import bmlg_pkg::*; #(
  parameter int NUM_BOXES = 11
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    cmd,
  input  logic [PIX_W-1:0]        pixel_word,
  input  logic [IDX_W-1:0]        box_index,
  input  logic signed [POS_W-1:0] box_x,
  input  logic signed [POS_W-1:0] box_y,
  input  logic [DIM_W-1:0]        box_size,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [PIX_W-1:0]        out_pixel_word,
  output int unsigned             fail_count,
  output int unsigned             words_owed,
  output int unsigned             pixels_seen,
  output int unsigned             greyed_seen,
  output int unsigned             box_loads_seen
);

  // BT.709 weights, Q0.16
  localparam int unsigned W_RED = 13933;
  localparam int unsigned W_GRN = 46871;
  localparam int unsigned W_BLU = 4732;

  logic [DIM_W-1:0]        width_q;
  logic [DIM_W-1:0]        height_q;
  logic [DIM_W-1:0]        col_q;
  logic [DIM_W-1:0]        row_q;
  logic [LUMA_W-1:0]       prev_luma_q;
  logic signed [POS_W-1:0] left_q [NUM_BOXES];
  logic signed [POS_W-1:0] top_q  [NUM_BOXES];
  logic [DIM_W-1:0]        side_q [NUM_BOXES];
  logic [PIX_W-1:0]        masked_words [$];
  int unsigned             words_checked;

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
    $display("%0t: output word %0d %s: got %06h, want %06h", $time, words_checked,
             what, got, want);
    fail_count++;
  endtask

  // Output word for one pixel; moves the raster position on by one.
  function automatic logic [PIX_W-1:0] mask_and_advance(input logic [PIX_W-1:0] pix);
    int                k;
    bit                hit;
    int unsigned       acc;
    logic [LUMA_W-1:0] luma;
    logic [LUMA_W-1:0] diff;
    logic [PIX_W-1:0]  word;
    hit = 1'b0;
    for (k = 0; k < NUM_BOXES; k++)
      if (int'(col_q) > int'(left_q[k]) && int'(col_q) < int'(left_q[k]) + int'(side_q[k]) &&
          int'(row_q) > int'(top_q[k])  && int'(row_q) < int'(top_q[k]) + int'(side_q[k]))
        hit = 1'b1;
    if (hit) begin
      acc  = W_RED * pix[7:0] + W_GRN * pix[15:8] + W_BLU * pix[23:16];
      luma = acc[23:16];
      diff = (luma >= prev_luma_q) ? luma - prev_luma_q : prev_luma_q - luma;
      prev_luma_q = luma;
      word = {3{diff}};
      greyed_seen++;
    end else begin
      word = pix;
    end
    // wrap test is >=, so a size of zero acts as one
    if (int'(col_q) + 1 >= int'(width_q)) begin
      col_q       = '0;
      prev_luma_q = '0;
      if (int'(row_q) + 1 >= int'(height_q))
        row_q = '0;
      else
        row_q = row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
    return word;
  endfunction

  always @(posedge clk) begin
    logic [PIX_W-1:0] want;
    if (rst) begin
      width_q     = FRAME_WIDTH_RST;
      height_q    = FRAME_HEIGHT_RST;
      col_q       = '0;
      row_q       = '0;
      prev_luma_q = '0;
      for (int k = 0; k < NUM_BOXES; k++) begin
        left_q[k] = '0;
        top_q[k]  = '0;
        side_q[k] = '0;
      end
      masked_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  width_q  = cfg_data;
          CFG_FRAME_HEIGHT: height_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (masked_words.size() == 0) begin
          report_mismatch("arrived with none owed", out_pixel_word, '0);
        end else begin
          want = masked_words.pop_front();
          if (out_pixel_word !== want)
            report_mismatch("differs", out_pixel_word, want);
        end
        words_checked++;
      end
      if (in_valid && !in_stall) begin
        if (cmd == CMD_BOX) begin
          box_loads_seen++;
          if (box_index < NUM_BOXES) begin
            left_q[box_index] = box_x;
            top_q[box_index]  = box_y;
            side_q[box_index] = box_size;
          end
        end else begin
          pixels_seen++;
          masked_words.push_back(mask_and_advance(pixel_word));
        end
      end
    end
    words_owed = masked_words.size();
  end

endmodule

@@ dv/box_masked_luma_gradient_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_masked_luma_gradient_core_test
// Drives pixel and box-load words into the core under changing frame sizes
// and stall patterns; a checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module box_masked_luma_gradient_core_test;
  import bmlg_pkg::*;

  localparam int NUM_BOXES   = 11;
  localparam int QUIET_LIMIT = 2000;  // cycles with no word moving
  localparam int SEG_WORDS   = 120;   // words per random segment; out-of-range box loads are extra

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic                    cfg_index = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    cmd = CMD_PIXEL;
  logic [PIX_W-1:0]        pixel_word = '0;
  logic [IDX_W-1:0]        box_index = '0;
  logic signed [POS_W-1:0] box_x = '0;
  logic signed [POS_W-1:0] box_y = '0;
  logic [DIM_W-1:0]        box_size = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [PIX_W-1:0]        out_pixel_word;

  int unsigned fail_count;
  int unsigned words_owed;
  int unsigned pixels_seen;
  int unsigned greyed_seen;
  int unsigned box_loads_seen;

  int tx_idle_pct = 0;      // chance per draw that the sender holds off before a word; redrawn until it sends
  int rx_idle_pct = 0;      // chance per cycle that the receiver stalls
  int quiet_cycles = 0;
  int frame_settings = 0;

  box_masked_luma_gradient_core #(.NUM_BOXES(NUM_BOXES)) dut (.*);

  box_masked_luma_gradient_checker #(.NUM_BOXES(NUM_BOXES)) checker_i (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver side: random stall per cycle
  always @(posedge clk)
    out_stall <= ($urandom_range(99, 0) < rx_idle_pct);

  // watchdog: ends the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: %0d quiet cycles, %0d output words still owed",
               QUIET_LIMIT, words_owed);
      $display("box_masked_luma_gradient_core_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One word on the input channel, held until taken. in_stall is read at the
  // falling edge, where it has settled for the coming rising edge.
  task automatic send_word(input logic c, input logic [PIX_W-1:0] pix,
                           input logic [IDX_W-1:0] idx, input logic signed [POS_W-1:0] x,
                           input logic signed [POS_W-1:0] y, input logic [DIM_W-1:0] sz);
    bit stalled;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    pixel_word <= pix;
    box_index  <= idx;
    box_x      <= x;
    box_y      <= y;
    box_size   <= sz;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // box fields carry noise on pixel words, and pixel bits on box loads
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    send_word(CMD_PIXEL, pix, IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
              DIM_W'($urandom));
  endtask

  task automatic load_box(input logic [IDX_W-1:0] idx, input int x, input int y,
                          input int sz);
    send_word(CMD_BOX, PIX_W'($urandom), idx, POS_W'(x), POS_W'(y), DIM_W'(sz));
  endtask

  // Sender pauses until every owed word is back, then waits on so that a
  // trailing box load has settled too.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // both frame registers back to back; only called while the core is idle
  task automatic set_frame(input int w, input int h);
    cfg_write <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= DIM_W'(w);
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= DIM_W'(h);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    frame_settings++;
  endtask

  // Mostly pixels with boxes placed near the visible rows and columns, so that
  // many words land inside; a share of loads are wild, out-of-range included.
  task automatic run_segment(input int w, input int h, input int n);
    int span_x, span_y, roll, sent, idx;
    span_x = (w > 60) ? 60 : w;
    span_y = (h > 60) ? 60 : h;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(999, 0);
      if (roll < 6)
        hold_until_drained();
      if (roll < 100 || sent < 3) begin
        if ($urandom_range(6, 0) == 0 && sent >= 3) begin
          idx = $urandom_range(15, 0);
          load_box(IDX_W'(idx), $urandom, $urandom, $urandom);
          if (idx < NUM_BOXES)
            sent++;
        end else begin
          load_box(IDX_W'($urandom_range(NUM_BOXES - 1, 0)),
                   int'($urandom_range(span_x + 1, 0)) - 2,
                   int'($urandom_range(span_y + 1, 0)) - 2,
                   $urandom_range(span_x + 3, 0));
          sent++;
        end
      end else begin
        if ($urandom_range(19, 0) == 0)
          send_pixel($urandom_range(1, 0) ? {PIX_W{1'b1}} : '0);
        else
          send_pixel(PIX_W'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    int fw, fh;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed: colour extremes in a box covering the whole frame ---
    set_frame(6, 4);
    load_box(0, -1, -1, 2047);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h0000FF);
    send_pixel(24'h00FF00);
    send_pixel(24'hFF0000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h808080);          // new row: previous luma cleared
    load_box(15, 2047, -2048, 2047); // index beyond the store, dropped
    load_box(10, -2048, 2047, 0);
    send_pixel(24'h123456);
    send_pixel(24'hFEDCBA);
    load_box(0, 0, 0, 0);            // box off, words pass through
    send_pixel(24'hA5C3E1);
    send_pixel(24'h5A3C1E);
    hold_until_drained();
    // zero size acts as one, and the counters sit beyond it
    set_frame(0, 0);
    load_box(1, -1, -1, 2);
    send_pixel(24'h40C080);
    send_pixel(24'hFFFFFF);
    hold_until_drained();
    set_frame(2047, 2047);
    send_pixel(PIX_W'($urandom));
    send_pixel(PIX_W'($urandom));

    // --- random: three stall patterns, three frame sizes each ---
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 48 : 0;
      rx_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 11 : 0;
      for (int seg = 0; seg < 3; seg++) begin
        case (ph * 3 + seg)
          2:       begin fw = 2047; fh = 3;    end
          5:       begin fw = 1;    fh = 2047; end
          7:       begin fw = 1;    fh = 1;    end
          default: begin
            fw = $urandom_range(24, 2);
            fh = $urandom_range(10, 1);
          end
        endcase
        hold_until_drained();
        set_frame(fw, fh);
        run_segment(fw, fh, SEG_WORDS);
      end
    end

    hold_until_drained();
    repeat (6) @(posedge clk);
    @(negedge clk);
    $display("covered %0d pixel words, %0d of them greyed inside boxes, and %0d box loads",
             pixels_seen, greyed_seen, box_loads_seen);
    $display("across %0d frame settings (zero, one and 2047 among them) and three stall mixes",
             frame_settings);
    if (fail_count == 0 && words_owed == 0)
      $display("box_masked_luma_gradient_core_test: PASS");
    else
      $display("box_masked_luma_gradient_core_test: FAIL");
    $finish;
  end

endmodule
